### src/ssft_pkg.sv
// Shared types and constants for the source session floor table.
`default_nettype none

package ssft_pkg;

   localparam int PORT_W      = 8;
   localparam int IDENT_W     = 8;
   localparam int ROLE_W      = 4;
   localparam int KEY_W       = ROLE_W + IDENT_W + PORT_W;
   localparam int FLOOR_W     = 32;
   localparam int GEN_W       = 32;
   localparam int STATUS_W    = 3;
   localparam int COPY_W      = 2;
   localparam int COUNT_OUT_W = 5;
   localparam int Q_DEPTH     = 2;

   localparam logic REQ_RAISE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISS      = 3'd4;

   localparam logic [COPY_W-1:0] COPY_NONE = 2'd0;
   localparam logic [COPY_W-1:0] COPY_A    = 2'd1;
   localparam logic [COPY_W-1:0] COPY_B    = 2'd2;

   typedef struct packed {
      logic               is_query;
      logic [KEY_W-1:0]   key;
      logic [FLOOR_W-1:0] floor_val;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EXEC,
      BK_RESP
   } back_state_type;

endpackage

`default_nettype wire

### src/ssft_if.sv
// Request and response channel interfaces.
`default_nettype none

interface ssft_req_if;
   import ssft_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [PORT_W-1:0]  ingress_port;
   logic [IDENT_W-1:0] link_identity;
   logic [ROLE_W-1:0]  link_role;
   logic [FLOOR_W-1:0] session_floor;
   modport source (output valid, req_type, ingress_port, link_identity, link_role,
                   session_floor, input ready);
   modport sink (input valid, req_type, ingress_port, link_identity, link_role,
                 session_floor, output ready);
endinterface

interface ssft_rsp_if;
   import ssft_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [FLOOR_W-1:0]     floor_value;
   logic [GEN_W-1:0]       generation_now;
   logic [COPY_W-1:0]      active_copy_now;
   logic [COUNT_OUT_W-1:0] entry_count;
   modport source (output valid, status, floor_value, generation_now, active_copy_now,
                   entry_count, input ready);
   modport sink (input valid, status, floor_value, generation_now, active_copy_now,
                 entry_count, output ready);
endinterface

`default_nettype wire

### src/ssft_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/ssft_front.sv
// Front end: accept and classify request transactions into a holding register.
`default_nettype none

module ssft_front (
   input  wire logic     clock,
   input  wire logic     reset,
   ssft_req_if.sink      req_chan,
   output logic          push_valid,
   output ssft_pkg::cmd_type push_cmd,
   input  wire logic     push_ready
);
   import ssft_pkg::*;

   logic    hold_v_ff, hold_v_in;
   cmd_type hold_ff, hold_in;
   logic    take;

   assign req_chan.ready = !hold_v_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_in = hold_ff;
      if (take) begin
         hold_in.is_query  = (req_chan.req_type == REQ_QUERY);
         hold_in.key       = {req_chan.link_role, req_chan.link_identity,
                              req_chan.ingress_port};
         hold_in.floor_val = req_chan.session_floor;
      end
   end

   always_comb begin
      if (take) begin
         hold_v_in = 1'b1;
      end else if (push_ready) begin
         hold_v_in = 1'b0;
      end else begin
         hold_v_in = hold_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign push_valid = hold_v_ff;
   assign push_cmd   = hold_ff;

endmodule

`default_nettype wire

### src/ssft_cmd_fifo.sv
// Short command queue between front end and back end.
`default_nettype none

module ssft_cmd_fifo (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  ssft_pkg::cmd_type push_cmd,
   output logic          push_ready,
   output logic          pop_valid,
   output ssft_pkg::cmd_type pop_cmd,
   input  wire logic     pop
);
   import ssft_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);

   cmd_type          slots_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### src/ssft_back.sv
// Back end: scan the slot table, apply the command and register the response.
`default_nettype none

module ssft_back #(
   parameter int ENTRIES = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     pop_valid,
   input  ssft_pkg::cmd_type pop_cmd,
   output logic          pop,
   ssft_rsp_if.source    rsp_chan
);
   import ssft_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int RAM_W = KEY_W + FLOOR_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

   back_state_type state_ff, state_in;

   cmd_type            cmd_ff, cmd_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic               issue_on_ff, issue_on_in;
   logic               chk_on_ff, chk_on_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [FLOOR_W-1:0] match_floor_ff, match_floor_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FLOOR_W-1:0] res_floor_ff, res_floor_in;

   logic [ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic [COPY_W-1:0]  copy_ff, copy_in;

   logic                   out_v_ff, out_v_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [FLOOR_W-1:0]     out_floor_ff, out_floor_in;
   logic [GEN_W-1:0]       out_gen_ff, out_gen_in;
   logic [COPY_W-1:0]      out_copy_ff, out_copy_in;
   logic [COUNT_OUT_W-1:0] out_count_ff, out_count_in;

   logic [RAM_W-1:0]   rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [FLOOR_W-1:0] rd_floor;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic               chk_slot_v;
   logic               hit_now;
   logic               last_chk;
   logic               store;
   logic               out_free;

   ssft_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({cmd_ff.key, cmd_ff.floor_val}),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign rd_key     = rd_data[RAM_W-1:FLOOR_W];
   assign rd_floor   = rd_data[FLOOR_W-1:0];
   assign chk_slot_v = slot_valid_ff[chk_idx_ff];
   assign out_free   = !out_v_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (hit_now || last_chk) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            state_in = BK_RESP;
         end
         BK_RESP: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      hit_now  = 1'b0;
      last_chk = 1'b0;
      store    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = match_ff ? match_idx_ff : free_idx_ff;
      case (state_ff)
         BK_IDLE: begin
            pop = pop_valid;
         end
         BK_SCAN: begin
            hit_now  = chk_on_ff && chk_slot_v && (rd_key == cmd_ff.key);
            last_chk = chk_on_ff && (chk_idx_ff == LAST);
         end
         BK_EXEC: begin
            if (!cmd_ff.is_query) begin
               store = match_ff ? (cmd_ff.floor_val > match_floor_ff) : free_found_ff;
            end
            wr_en = store;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd_in         = cmd_ff;
      scan_in        = scan_ff;
      issue_on_in    = issue_on_ff;
      chk_on_in      = chk_on_ff;
      chk_idx_in     = chk_idx_ff;
      match_in       = match_ff;
      match_idx_in   = match_idx_ff;
      match_floor_in = match_floor_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      res_status_in  = res_status_ff;
      res_floor_in   = res_floor_ff;
      slot_valid_in  = slot_valid_ff;
      count_in       = count_ff;
      gen_in         = gen_ff;
      copy_in        = copy_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               cmd_in        = pop_cmd;
               scan_in       = '0;
               issue_on_in   = 1'b1;
               chk_on_in     = 1'b0;
               match_in      = 1'b0;
               free_found_in = 1'b0;
            end
         end
         BK_SCAN: begin
            chk_on_in  = issue_on_ff;
            chk_idx_in = scan_ff;
            if (issue_on_ff) begin
               if (scan_ff == LAST) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_in = scan_ff + IDX_W'(1);
               end
            end
            if (chk_on_ff && !chk_slot_v && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
            if (hit_now) begin
               match_in       = 1'b1;
               match_idx_in   = chk_idx_ff;
               match_floor_in = rd_floor;
            end
         end
         BK_EXEC: begin
            if (cmd_ff.is_query) begin
               res_status_in = match_ff ? ST_HIT : ST_MISS;
               res_floor_in  = match_ff ? match_floor_ff : '0;
            end else if (store) begin
               res_status_in = ST_UPDATED;
               res_floor_in  = cmd_ff.floor_val;
               gen_in        = gen_ff + GEN_W'(1);
               copy_in       = (copy_ff == COPY_A) ? COPY_B : COPY_A;
               if (!match_ff) begin
                  slot_valid_in[free_idx_ff] = 1'b1;
                  count_in                   = count_ff + CNT_W'(1);
               end
            end else if (match_ff) begin
               res_status_in = ST_UNCHANGED;
               res_floor_in  = match_floor_ff;
            end else begin
               res_status_in = ST_FULL;
               res_floor_in  = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_status_in = out_status_ff;
      out_floor_in  = out_floor_ff;
      out_gen_in    = out_gen_ff;
      out_copy_in   = out_copy_ff;
      out_count_in  = out_count_ff;
      if ((state_ff == BK_RESP) && out_free) begin
         out_v_in      = 1'b1;
         out_status_in = res_status_ff;
         out_floor_in  = res_floor_ff;
         out_gen_in    = gen_ff;
         out_copy_in   = copy_ff;
         out_count_in  = COUNT_OUT_W'(count_ff);
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end else begin
         out_v_in = out_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         slot_valid_ff <= '0;
         count_ff      <= '0;
         gen_ff        <= '0;
         copy_ff       <= COPY_NONE;
         out_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
         gen_ff        <= gen_in;
         copy_ff       <= copy_in;
         out_v_ff      <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      scan_ff        <= scan_in;
      issue_on_ff    <= issue_on_in;
      chk_on_ff      <= chk_on_in;
      chk_idx_ff     <= chk_idx_in;
      match_ff       <= match_in;
      match_idx_ff   <= match_idx_in;
      match_floor_ff <= match_floor_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      res_status_ff  <= res_status_in;
      res_floor_ff   <= res_floor_in;
      out_status_ff  <= out_status_in;
      out_floor_ff   <= out_floor_in;
      out_gen_ff     <= out_gen_in;
      out_copy_ff    <= out_copy_in;
      out_count_ff   <= out_count_in;
   end

   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.floor_value     = out_floor_ff;
   assign rsp_chan.generation_now  = out_gen_ff;
   assign rsp_chan.active_copy_now = out_copy_ff;
   assign rsp_chan.entry_count     = out_count_ff;

`ifndef SYNTHESIS
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == int'(count_ff))
      else $error("entry count differs from number of valid slots");

   a_gen_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (gen_ff != $past(gen_ff))) |-> ($past(state_ff) == BK_EXEC))
      else $error("generation changed outside commit");

   a_copy_follows_gen: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((gen_ff != $past(gen_ff)) == (copy_ff != $past(copy_ff))))
      else $error("active copy and generation out of step");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(out_v_ff)) |-> ($past(state_ff) == BK_RESP))
      else $error("response raised outside response state");
`endif

endmodule

`default_nettype wire

### src/source_session_floor_table.sv
// Top level of the per-source session floor table.
// A request passes the front-end holding register and the command queue to the back end,
// then a key scan, a commit step and a response load step.
// The back end takes one transaction at a time; the scan through the single read port
// of the slot RAM (one slot per cycle, registered read) sets its pace.
// Reset: synchronous; clears valid bits, entry count, generation and active copy.
`default_nettype none

module source_session_floor_table #(
   parameter int ENTRIES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   ssft_req_if.sink  req_chan,
   ssft_rsp_if.source rsp_chan
);
   import ssft_pkg::*;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   ssft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   ssft_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   ssft_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
